### rtl/bha_pkg.sv
// ----------------------------------------------------------------------------
// Block heap allocator package
// Shared constants, codes and types for the allocator sequencer, its entry
// memory and its shared adder.
// ----------------------------------------------------------------------------
package bha_pkg;

	localparam int MAX_BLOCKS    = 64;
	localparam int IDX_W         = $clog2(MAX_BLOCKS);
	localparam int CNT_W         = IDX_W + 1;
	localparam int GRANULE_BYTES = 32;

	localparam logic [31:0] FAIL_ADDR = 32'hEFFF_FFFE;
	localparam logic [31:0] GRAN_MASK = 32'(GRANULE_BYTES - 1);

	// Request codes.
	localparam logic [1:0] REQ_FIRST_FIT = 2'd0;
	localparam logic [1:0] REQ_NEXT_FIT  = 2'd1;
	localparam logic [1:0] REQ_FREE      = 2'd2;
	localparam logic [1:0] REQ_CLEAR     = 2'd3;

	// Status codes.
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_NOFIT    = 3'd1;
	localparam logic [2:0] ST_NOTFOUND = 3'd2;
	localparam logic [2:0] ST_ALREADY  = 3'd3;
	localparam logic [2:0] ST_FULL     = 3'd4;

	// One table entry as stored in the memory.
	typedef struct packed {
		logic        used;
		logic [30:0] size;
		logic [31:0] start;
	} entry_t;

	typedef enum logic {
		ALU_ADD,
		ALU_SUB
	} alu_op_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_HINT_RD,
		S_HINT_CHK,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_SPLIT_ADD,
		S_UP_RD,
		S_UP_WR,
		S_WR_REM,
		S_WR_USED,
		S_PREV_RD,
		S_PREV_CHK,
		S_NEXT_RD,
		S_NEXT_CHK,
		S_SUM1,
		S_SUM2,
		S_WR_MERGE,
		S_DN_RD,
		S_DN_WR,
		S_FREE_FIN,
		S_DONE
	} state_t;

endpackage

### rtl/bha_ram.sv
// ----------------------------------------------------------------------------
// Block heap allocator entry memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bha_ram (
	input  logic                       clk,
	input  logic                       we,
	input  logic [bha_pkg::IDX_W-1:0]  waddr,
	input  bha_pkg::entry_t            wdata,
	input  logic [bha_pkg::IDX_W-1:0]  raddr,
	output bha_pkg::entry_t            rdata
);
	import bha_pkg::*;

	entry_t mem_q [MAX_BLOCKS];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/bha_alu.sv
// ----------------------------------------------------------------------------
// Block heap allocator shared adder
// One 32-bit adder used for sums, differences and compares.
// ----------------------------------------------------------------------------
module bha_alu (
	input  bha_pkg::alu_op_t op,
	input  logic [31:0]      a,
	input  logic [31:0]      b,
	output logic [31:0]      res,
	output logic             carry,
	output logic             zero
);
	import bha_pkg::*;

	logic [31:0] b_eff;
	logic        sub;

	// On a subtract the carry out means a >= b.
	assign sub          = (op == ALU_SUB);
	assign b_eff        = sub ? ~b : b;
	assign {carry, res} = {1'b0, a} + {1'b0, b_eff} + {32'd0, sub};
	assign zero         = (res == 32'd0);

endmodule

### rtl/block_heap_allocator.sv
// ----------------------------------------------------------------------------
// Block heap allocator
// Address-ordered table of heap blocks with first-fit and next-fit
// allocation, splitting, free with coalescing and full reinitialization.
//
//   Channel   Direction  Handshake             Payload
//   request   in         in_valid / in_stall   req_type, alloc_size, free_addr
//   result    out        out_valid / out_stall status, block_addr
//   config    in         APB psel / penable    paddr, pwdata, prdata
//
// A clear goes straight to the result. An allocation reads each entry scanned,
// and when a split inserts a new entry it moves each later entry up; a free
// reads each entry scanned and moves each later entry down after a merge.
// All of these reads go through the single read port of the entry memory.
// Reset leaves one free entry (heap_base, heap_size); no clearing pass.
// A stalled result holds the sequencer in its final state.
// ----------------------------------------------------------------------------
module block_heap_allocator (
	input  logic        clk,
	input  logic        arst_n,
	// Request channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [30:0] alloc_size,
	input  logic [31:0] free_addr,
	// Result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [31:0] block_addr,
	// Configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import bha_pkg::*;

	state_t state_q, state_d;

	logic [31:0]      heap_base_q;
	logic [30:0]      heap_size_q;
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] hint_q;
	logic             e0_q;
	logic             rd_e0_q;

	logic [1:0]       op_q;
	logic [31:0]      need_q;
	logic [31:0]      addr_q;
	logic [CNT_W-1:0] idx_q;
	logic [CNT_W-1:0] k_q;
	logic [31:0]      cur_start_q;
	logic [30:0]      cur_size_q;
	logic [30:0]      rem_size_q;
	logic [31:0]      rem_start_q;
	logic             split_q;
	logic             pf_q;
	logic             nf_q;
	logic [30:0]      prev_size_q;
	logic [31:0]      prev_start_q;
	logic [30:0]      next_size_q;
	logic [30:0]      sum_q;
	logic [IDX_W-1:0] b_q;
	logic [1:0]       m_q;

	logic             out_valid_q;
	logic [2:0]       status_q;
	logic [31:0]      block_addr_q;
	logic [2:0]       res_status_q;
	logic [31:0]      res_addr_q;

	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	entry_t           mem_wdata;
	logic [IDX_W-1:0] mem_raddr;
	entry_t           mem_rdata;
	entry_t           ent;

	alu_op_t          alu_op;
	logic [31:0]      alu_a, alu_b, alu_res;
	logic             alu_carry, alu_zero;

	logic             cfg_we;
	logic             accept;
	logic             out_load;
	logic             is_free;
	logic             fit;
	logic [31:0]      need_d;
	logic [CNT_W-1:0] idx_p1, k_m1, k_p1, cnt_m1, shift_src;
	logic [IDX_W-1:0] hint_new, b_new;
	logic [1:0]       m_new;

	bha_ram u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	bha_alu u_alu (
		.op    (alu_op),
		.a     (alu_a),
		.b     (alu_b),
		.res   (alu_res),
		.carry (alu_carry),
		.zero  (alu_zero)
	);

	// Handshakes and small helpers.
	assign pready     = 1'b1;
	assign cfg_we     = psel && penable && pwrite;
	assign prdata     = paddr[2] ? {1'b0, heap_size_q} : heap_base_q;
	assign in_stall   = (state_q != S_IDLE);
	assign accept     = in_valid && !in_stall;
	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign block_addr = block_addr_q;
	assign out_load   = (state_q == S_DONE) && (!out_valid_q || !out_stall);
	assign is_free    = (op_q == REQ_FREE);
	assign need_d     = ({1'b0, alloc_size} + GRAN_MASK) & ~GRAN_MASK;
	assign idx_p1     = idx_q + CNT_W'(1);
	assign k_m1       = k_q - CNT_W'(1);
	assign k_p1       = k_q + CNT_W'(1);
	assign cnt_m1     = count_q - CNT_W'(1);
	assign shift_src  = CNT_W'(b_q) + CNT_W'(1) + CNT_W'(m_q);
	assign fit        = !ent.used && alu_carry;

	// Entry 0 reads as the configured region until it is first written.
	assign ent = rd_e0_q ? entry_t'{used: 1'b0, size: heap_size_q, start: heap_base_q}
	                     : mem_rdata;

	// Merge base, removed count and hint after up to two removals.
	always_comb begin
		logic [IDX_W-1:0] c, h, r;
		c = idx_q[IDX_W-1:0];
		h = hint_q;
		b_new = pf_q ? c - IDX_W'(1) : c;
		m_new = {1'b0, pf_q} + {1'b0, nf_q};
		if (pf_q) begin
			if (h > c) begin
				h = h - IDX_W'(1);
			end else if (h == c) begin
				h = c - IDX_W'(1);
			end
		end
		r = b_new + IDX_W'(1);
		if (nf_q) begin
			if (h > r) begin
				h = h - IDX_W'(1);
			end else if (h == r) begin
				h = b_new;
			end
		end
		hint_new = h;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					case (req_type)
						REQ_CLEAR:    state_d = S_DONE;
						REQ_NEXT_FIT: state_d = (CNT_W'(hint_q) < count_q) ? S_HINT_RD
						                                                   : S_SCAN_RD;
						default:      state_d = S_SCAN_RD;
					endcase
				end
			end
			S_HINT_RD:   state_d = S_HINT_CHK;
			S_HINT_CHK:  state_d = S_SCAN_RD;
			S_SCAN_RD:   state_d = (idx_q == count_q) ? S_DONE : S_SCAN_CHK;
			S_SCAN_CHK: begin
				if (is_free) begin
					if (ent.start == addr_q) begin
						if (!ent.used) begin
							state_d = S_DONE;
						end else begin
							state_d = (idx_q != '0) ? S_PREV_RD : S_NEXT_RD;
						end
					end else begin
						state_d = S_SCAN_RD;
					end
				end else if (fit) begin
					if (alu_zero) begin
						state_d = S_WR_USED;
					end else if (count_q == CNT_W'(MAX_BLOCKS)) begin
						state_d = S_DONE;
					end else begin
						state_d = S_SPLIT_ADD;
					end
				end else begin
					state_d = S_SCAN_RD;
				end
			end
			S_SPLIT_ADD: state_d = (cnt_m1 > idx_q) ? S_UP_RD : S_WR_REM;
			S_UP_RD:     state_d = S_UP_WR;
			S_UP_WR:     state_d = (k_m1 > idx_q) ? S_UP_RD : S_WR_REM;
			S_WR_REM:    state_d = S_WR_USED;
			S_WR_USED:   state_d = S_DONE;
			S_PREV_RD:   state_d = S_PREV_CHK;
			S_PREV_CHK:  state_d = S_NEXT_RD;
			S_NEXT_RD:   state_d = (idx_p1 < count_q) ? S_NEXT_CHK : S_SUM1;
			S_NEXT_CHK:  state_d = S_SUM1;
			S_SUM1:      state_d = S_SUM2;
			S_SUM2:      state_d = S_WR_MERGE;
			S_WR_MERGE:  state_d = ((m_q != 2'd0) && (shift_src < count_q)) ? S_DN_RD
			                                                                : S_FREE_FIN;
			S_DN_RD:     state_d = S_DN_WR;
			S_DN_WR:     state_d = (k_p1 < count_q) ? S_DN_RD : S_FREE_FIN;
			S_FREE_FIN:  state_d = S_DONE;
			S_DONE:      state_d = out_load ? S_IDLE : S_DONE;
			default:     state_d = S_IDLE;
		endcase
	end

	// Memory and adder controls.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_raddr = '0;
		alu_op    = ALU_SUB;
		alu_a     = {1'b0, ent.size};
		alu_b     = need_q;
		case (state_q)
			S_HINT_RD: mem_raddr = hint_q;
			S_SCAN_RD: mem_raddr = idx_q[IDX_W-1:0];
			S_SCAN_CHK: begin
				if (is_free) begin
					alu_a = ent.start;
					alu_b = addr_q;
				end
			end
			S_SPLIT_ADD: begin
				alu_op = ALU_ADD;
				alu_a  = cur_start_q;
				alu_b  = need_q;
			end
			S_UP_RD: mem_raddr = k_q[IDX_W-1:0];
			S_UP_WR: begin
				mem_we    = 1'b1;
				mem_waddr = k_p1[IDX_W-1:0];
				mem_wdata = ent;
			end
			S_WR_REM: begin
				mem_we    = 1'b1;
				mem_waddr = idx_p1[IDX_W-1:0];
				mem_wdata = '{used: 1'b0, size: rem_size_q, start: rem_start_q};
			end
			S_WR_USED: begin
				mem_we    = 1'b1;
				mem_waddr = idx_q[IDX_W-1:0];
				mem_wdata = '{used: 1'b1, size: need_q[30:0], start: cur_start_q};
			end
			S_PREV_RD: mem_raddr = idx_q[IDX_W-1:0] - IDX_W'(1);
			S_NEXT_RD: mem_raddr = idx_p1[IDX_W-1:0];
			S_SUM1: begin
				alu_op = ALU_ADD;
				alu_a  = {1'b0, cur_size_q};
				alu_b  = pf_q ? {1'b0, prev_size_q} : 32'd0;
			end
			S_SUM2: begin
				alu_op = ALU_ADD;
				alu_a  = {1'b0, sum_q};
				alu_b  = nf_q ? {1'b0, next_size_q} : 32'd0;
			end
			S_WR_MERGE: begin
				mem_we    = 1'b1;
				mem_waddr = b_q;
				mem_wdata = '{used: 1'b0, size: sum_q,
				              start: pf_q ? prev_start_q : cur_start_q};
			end
			S_DN_RD: mem_raddr = k_q[IDX_W-1:0];
			S_DN_WR: begin
				mem_we    = 1'b1;
				mem_waddr = k_q[IDX_W-1:0] - IDX_W'(m_q);
				mem_wdata = ent;
			end
			default: ;
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			heap_base_q <= '0;
			heap_size_q <= '0;
			count_q     <= CNT_W'(1);
			hint_q      <= '0;
			e0_q        <= 1'b1;
			rd_e0_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_e0_q <= e0_q && (mem_raddr == '0);

			if (mem_we && (mem_waddr == '0)) begin
				e0_q <= 1'b0;
			end

			// Register writes rebuild the table.
			if (cfg_we) begin
				if (paddr[2]) begin
					heap_size_q <= pwdata[30:0];
				end else begin
					heap_base_q <= pwdata;
				end
				count_q <= CNT_W'(1);
				hint_q  <= '0;
				e0_q    <= 1'b1;
			end

			if (accept && (req_type == REQ_CLEAR)) begin
				count_q <= CNT_W'(1);
				hint_q  <= '0;
				e0_q    <= 1'b1;
			end

			if ((state_q == S_WR_USED) && split_q) begin
				count_q <= count_q + CNT_W'(1);
				hint_q  <= idx_p1[IDX_W-1:0];
			end

			if (state_q == S_SUM2) begin
				hint_q <= hint_new;
			end

			if (state_q == S_FREE_FIN) begin
				count_q <= count_q - CNT_W'(m_q);
			end

			// Output register.
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working registers of the sequencer.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				op_q         <= req_type;
				need_q       <= need_d;
				addr_q       <= free_addr;
				idx_q        <= '0;
				res_status_q <= ST_OK;
				res_addr_q   <= '0;
			end
			S_HINT_CHK: idx_q <= alu_carry ? CNT_W'(hint_q) : '0;
			S_SCAN_RD: begin
				if (idx_q == count_q) begin
					res_status_q <= is_free ? ST_NOTFOUND : ST_NOFIT;
					res_addr_q   <= is_free ? 32'd0 : FAIL_ADDR;
				end
			end
			S_SCAN_CHK: begin
				cur_start_q <= ent.start;
				cur_size_q  <= ent.size;
				rem_size_q  <= alu_res[30:0];
				split_q     <= !alu_zero;
				pf_q        <= 1'b0;
				nf_q        <= 1'b0;
				if (is_free) begin
					if (ent.start != addr_q) begin
						idx_q <= idx_p1;
					end else if (!ent.used) begin
						res_status_q <= ST_ALREADY;
					end
				end else if (fit) begin
					if (!alu_zero && (count_q == CNT_W'(MAX_BLOCKS))) begin
						res_status_q <= ST_FULL;
						res_addr_q   <= FAIL_ADDR;
					end
				end else begin
					idx_q <= idx_p1;
				end
			end
			S_SPLIT_ADD: begin
				rem_start_q <= alu_res;
				k_q         <= cnt_m1;
			end
			S_UP_WR:   k_q <= k_m1;
			S_WR_USED: res_addr_q <= cur_start_q;
			S_PREV_CHK: begin
				pf_q         <= !ent.used;
				prev_size_q  <= ent.size;
				prev_start_q <= ent.start;
			end
			S_NEXT_CHK: begin
				nf_q        <= !ent.used;
				next_size_q <= ent.size;
			end
			S_SUM1: sum_q <= alu_res[30:0];
			S_SUM2: begin
				sum_q <= alu_res[30:0];
				b_q   <= b_new;
				m_q   <= m_new;
			end
			S_WR_MERGE: k_q <= shift_src;
			S_DN_WR:    k_q <= k_p1;
			default: ;
		endcase
		if (out_load) begin
			status_q     <= res_status_q;
			block_addr_q <= res_addr_q;
		end
	end

`ifndef NO_ASSERTIONS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q >= CNT_W'(1)) && (count_q <= CNT_W'(MAX_BLOCKS)))
		else $error("entry count out of range");

	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !mem_we)
		else $error("memory written while idle");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != S_IDLE))
		else $error("sequencer stayed idle after a request");

	a_split_grows: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_WR_USED) && split_q && !cfg_we) |=>
		(count_q == $past(count_q) + CNT_W'(1)))
		else $error("split did not add an entry");
`endif

endmodule
